@@ rtl/rtp_pkg.sv @@
// Shared types and constants for the rigid transform pinhole projection block.
// No dependencies.
`timescale 1ns / 1ps
package rtp_pkg;

    localparam int COORD_W = 32;
    localparam int ROT_W   = 16;
    localparam int ROT_FRAC = 14;
    localparam int ROW_W   = 3 * ROT_W;
    localparam int PIX_W   = 16;
    localparam int PROD_W  = COORD_W + ROT_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CAM_W   = COORD_W + 5;
    localparam int NUM_W   = CAM_W + PIX_W + 2;
    localparam int DEN_W   = CAM_W + 4;
    localparam int Q_BITS  = PIX_W;
    localparam int REM_W   = DEN_W + Q_BITS;
    localparam int CFG_W   = ROW_W;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_ROT_ROW0  = 3'd0,
        REG_ROT_ROW1  = 3'd1,
        REG_ROT_ROW2  = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5,
        REG_FOCAL     = 3'd6,
        REG_PRINCIPAL = 3'd7
    } reg_idx_t;

    localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;
    localparam logic [31:0] FOCAL_RST     = 32'h3E80_3E80;
    localparam logic [31:0] PRINCIPAL_RST = 32'h0F00_1400;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_u;
        logic signed [PIX_W-1:0] pixel_v;
        logic                    in_front;
        logic                    clipped;
    } out_item_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]   rot;
        logic [2:0][COORD_W-1:0] shift;
        logic [31:0]             focal;
        logic [31:0]             principal;
    } cfg_t;

    typedef struct packed {
        logic signed [CAM_W-1:0] x;
        logic signed [CAM_W-1:0] y;
        logic signed [CAM_W-1:0] z;
    } cam_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem_u;
        logic [REM_W-1:0]  rem_v;
        logic [DEN_W-1:0]  den;
        logic [Q_BITS-1:0] q_u;
        logic [Q_BITS-1:0] q_v;
        logic              neg_u;
        logic              neg_v;
        logic              ovf_u;
        logic              ovf_v;
        logic              front;
    } div_t;

endpackage

@@ rtl/rigid_transform_pinhole_projection.sv @@
// Top level: configuration registers and the transform, projection and divider pipeline.
// Depends on rtp_pkg, rtp_transform, rtp_project, rtp_divider.
// The pipeline has 23 register stages from request accept to result valid.
// Throughput: one point per cycle; each stage holds under back-pressure, empty stages fill.
// The 16-stage restoring divider sets the depth.
// Reset (aresetn low, synchronous) empties the pipeline and restores register defaults.
`timescale 1ns / 1ps
module rigid_transform_pinhole_projection import rtp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_payload
);
    cfg_t cfg_reg;
    logic t_valid, t_ready, p_valid, p_ready;
    cam_t t_data;
    div_t p_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot[0] <= ROT_ROW0_RST;
            cfg_reg.rot[1] <= ROT_ROW1_RST;
            cfg_reg.rot[2] <= ROT_ROW2_RST;
            cfg_reg.shift <= '0;
            cfg_reg.focal <= FOCAL_RST;
            cfg_reg.principal <= PRINCIPAL_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_ROT_ROW0:  cfg_reg.rot[0] <= cfg_data;
                REG_ROT_ROW1:  cfg_reg.rot[1] <= cfg_data;
                REG_ROT_ROW2:  cfg_reg.rot[2] <= cfg_data;
                REG_SHIFT_X:   cfg_reg.shift[0] <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Y:   cfg_reg.shift[1] <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Z:   cfg_reg.shift[2] <= cfg_data[COORD_W-1:0];
                REG_FOCAL:     cfg_reg.focal <= cfg_data[31:0];
                REG_PRINCIPAL: cfg_reg.principal <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    rtp_transform u_transform (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_payload),
        .out_valid(t_valid), .out_ready(t_ready), .out_data(t_data)
    );

    rtp_project u_project (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(t_valid), .in_ready(t_ready), .in_data(t_data),
        .out_valid(p_valid), .out_ready(p_ready), .out_data(p_data)
    );

    rtp_divider u_divider (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(p_valid), .in_ready(p_ready), .in_data(p_data),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(m_payload)
    );

    // input stalls only when the whole pipe is full behind a held result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    a_clip_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.clipped |->
            m_payload.pixel_u == 16'sh7FFF || m_payload.pixel_u == -16'sh8000 ||
            m_payload.pixel_v == 16'sh7FFF || m_payload.pixel_v == -16'sh8000)
        else $error("clipped set without a saturated coordinate");
endmodule

@@ rtl/rtp_transform.sv @@
// Rotation and translation: sensor point to camera coordinates, two stages.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
module rtp_transform import rtp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cam_t     out_data
);
    logic v1_reg, v2_reg;
    logic rdy1, rdy2;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    cam_t cam_reg, cam_next;
    logic signed [COORD_W-1:0] pt [3];

    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v2_reg;
    assign out_data = cam_reg;

    assign pt[0] = in_data.point_x;
    assign pt[1] = in_data.point_y;
    assign pt[2] = in_data.point_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = $signed(cfg.rot[r][c*ROT_W +: ROT_W]) * pt[c];
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] s [3];
        logic signed [CAM_W-1:0] a [3];
        for (int r = 0; r < 3; r++) begin
            s[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1]) + SUM_W'(prod_reg[r][2]);
            // floor to Q16.16, then add translation
            a[r] = CAM_W'(s[r] >>> ROT_FRAC) + CAM_W'($signed(cfg.shift[r]));
        end
        cam_next.x = a[0];
        cam_next.y = a[1];
        cam_next.z = a[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) prod_reg <= prod_next;
        if (rdy2 && v1_reg) cam_reg <= cam_next;
    end
endmodule

@@ rtl/rtp_project.sv @@
// Pinhole numerators, magnitudes and overflow test ahead of the divider.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
module rtp_project import rtp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  cam_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [NUM_W-1:0] fu_reg, cu_reg, fv_reg, cv_reg;
    logic front1_reg;
    logic [DEN_W-1:0] den1_reg;

    logic signed [NUM_W-1:0] nu_reg, nv_reg;
    logic front2_reg;
    logic [DEN_W-1:0] den2_reg;

    logic [REM_W-1:0] mu_reg, mv_reg;
    logic neg_u_reg, neg_v_reg, front3_reg;
    logic [DEN_W-1:0] den3_reg;

    div_t d_reg, d_next;
    logic front_in;
    logic [REM_W-1:0] lim;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v4_reg;
    assign out_data = d_reg;

    assign front_in = in_data.z > 0;

    assign lim = {den3_reg, {Q_BITS{1'b0}}};
    always_comb begin
        d_next.rem_u = mu_reg;
        d_next.rem_v = mv_reg;
        d_next.den   = den3_reg;
        d_next.q_u   = '0;
        d_next.q_v   = '0;
        d_next.neg_u = neg_u_reg;
        d_next.neg_v = neg_v_reg;
        d_next.ovf_u = mu_reg >= lim;
        d_next.ovf_v = mv_reg >= lim;
        d_next.front = front3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            fu_reg <= $signed({1'b0, cfg.focal[15:0]}) * in_data.x;
            cu_reg <= $signed({1'b0, cfg.principal[15:0]}) * in_data.z;
            fv_reg <= $signed({1'b0, cfg.focal[31:16]}) * in_data.y;
            cv_reg <= $signed({1'b0, cfg.principal[31:16]}) * in_data.z;
            front1_reg <= front_in;
            den1_reg <= front_in ? {in_data.z[CAM_W-2:0], 5'b0} >> 1 : '0;
        end
        if (rdy2 && v1_reg) begin
            nu_reg <= fu_reg + cu_reg;
            nv_reg <= fv_reg + cv_reg;
            front2_reg <= front1_reg;
            den2_reg <= den1_reg;
        end
        if (rdy3 && v2_reg) begin
            mu_reg <= REM_W'(nu_reg[NUM_W-1] ? -nu_reg : nu_reg);
            mv_reg <= REM_W'(nv_reg[NUM_W-1] ? -nv_reg : nv_reg);
            neg_u_reg <= nu_reg[NUM_W-1];
            neg_v_reg <= nv_reg[NUM_W-1];
            front3_reg <= front2_reg;
            den3_reg <= den2_reg;
        end
        if (rdy4 && v3_reg) d_reg <= d_next;
    end
endmodule

@@ rtl/rtp_divider.sv @@
// Restoring divider, one quotient bit per stage, then sign and saturation.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
module rtp_divider import rtp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_t      in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    localparam logic [Q_BITS-1:0] POS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic [Q_BITS-1:0] NEG_MAG = {1'b1, {(Q_BITS-1){1'b0}}};

    logic v_reg [Q_BITS];
    logic rdy [Q_BITS];
    div_t st_reg [Q_BITS];
    div_t st_next [Q_BITS];
    logic vo_reg, rdy_o;
    out_item_t o_reg, o_next;

    assign rdy_o = !vo_reg || out_ready;
    // ready ripples back from the output, so walk the stages last to first
    always_comb begin
        for (int s = Q_BITS - 1; s >= 0; s--) begin
            rdy[s] = !v_reg[s] || ((s == Q_BITS - 1) ? rdy_o : rdy[(s + 1) % Q_BITS]);
        end
    end
    assign in_ready = rdy[0];
    assign out_valid = vo_reg;
    assign out_data = o_reg;

    always_comb begin
        div_t src;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < Q_BITS; s++) begin
            src = (s == 0) ? in_data : st_reg[(s + Q_BITS - 1) % Q_BITS];
            trial = REM_W'(src.den) << (Q_BITS - 1 - s);
            st_next[s] = src;
            if (src.rem_u >= trial) begin
                st_next[s].rem_u = src.rem_u - trial;
                st_next[s].q_u[Q_BITS-1-s] = 1'b1;
            end
            if (src.rem_v >= trial) begin
                st_next[s].rem_v = src.rem_v - trial;
                st_next[s].q_v[Q_BITS-1-s] = 1'b1;
            end
        end
    end

    function automatic logic [Q_BITS:0] saturate(input logic [Q_BITS-1:0] q,
                                                 input logic neg, input logic ovf);
        logic [Q_BITS:0] r;
        if (!neg) begin
            if (ovf || q > POS_MAX) r = {1'b1, POS_MAX};
            else r = {1'b0, q};
        end else begin
            if (ovf || q > NEG_MAG) r = {1'b1, NEG_MAG};
            else r = {1'b0, -q};
        end
        return r;
    endfunction

    always_comb begin
        div_t f;
        logic [Q_BITS:0] su, sv;
        f = st_reg[Q_BITS-1];
        su = saturate(f.q_u, f.neg_u, f.ovf_u);
        sv = saturate(f.q_v, f.neg_v, f.ovf_v);
        if (f.front) begin
            o_next.pixel_u = $signed(su[Q_BITS-1:0]);
            o_next.pixel_v = $signed(sv[Q_BITS-1:0]);
            o_next.clipped = su[Q_BITS] | sv[Q_BITS];
        end else begin
            o_next.pixel_u = '0;
            o_next.pixel_v = '0;
            o_next.clipped = 1'b0;
        end
        o_next.in_front = f.front;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < Q_BITS; s++) v_reg[s] <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            for (int s = 0; s < Q_BITS; s++) begin
                if (rdy[s]) v_reg[s] <= (s == 0) ? in_valid : v_reg[(s + Q_BITS - 1) % Q_BITS];
            end
            if (rdy_o) vo_reg <= v_reg[Q_BITS-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < Q_BITS; s++) begin
            if (rdy[s]) st_reg[s] <= st_next[s];
        end
        if (rdy_o && v_reg[Q_BITS-1]) o_reg <= o_next;
    end

    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg && !o_reg.in_front |-> o_reg.pixel_u == 0 && o_reg.pixel_v == 0
                                      && !o_reg.clipped)
        else $error("point behind camera with nonzero result");
endmodule
